// ----- src/sjl_pkg.sv -----
package sjl_pkg;

	localparam int JOINT_COUNT   = 24;
	localparam int ANGLE_LOWEST  = -800;
	localparam int ANGLE_HIGHEST = 800;
	localparam int PULSE_LOW     = 614;
	localparam int PULSE_HIGH    = 3072;

	localparam int JOINT_W = 5;
	localparam int JIDX_W  = $clog2(JOINT_COUNT);
	localparam int OP_W    = 3;
	localparam int AIN_W   = 12;
	localparam int ANGLE_W = 11;
	localparam int PULSE_W = 12;
	localparam int PULSE_MAX = (1 << PULSE_W) - 1;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	// Joints that take a centered pulse instead of the linear map.
	localparam int SPECIAL_JOINT_A = 0;
	localparam int SPECIAL_JOINT_B = 12;
	localparam int CENTER_PULSE    = 90;
	localparam int ANGLE_SCALE     = 10;

	localparam int ANGLE_SPAN = ANGLE_HIGHEST - ANGLE_LOWEST;
	localparam int PULSE_SPAN = PULSE_HIGH - PULSE_LOW;
	localparam bit PULSE_SPAN_NEG = (PULSE_SPAN < 0);
	localparam int PULSE_SPAN_ABS = PULSE_SPAN_NEG ? -PULSE_SPAN : PULSE_SPAN;

	// Constant division by reciprocal multiplication with one correction step.
	localparam int P_W      = 2 * AIN_W;
	localparam int RCP_SH   = 26;
	localparam int RCP_W    = RCP_SH;
	localparam int DIV_W    = AIN_W;
	localparam longint RCP_SPAN  = (64'sd1 <<< RCP_SH) / ANGLE_SPAN;
	localparam longint RCP_SCALE = (64'sd1 <<< RCP_SH) / ANGLE_SCALE;

	localparam logic signed [ANGLE_W-1:0] ANG_LO = ANGLE_W'(ANGLE_LOWEST);
	localparam logic signed [ANGLE_W-1:0] ANG_HI = ANGLE_W'(ANGLE_HIGHEST);
	localparam logic signed [AIN_W-1:0] ANG_LO_IN = AIN_W'(ANGLE_LOWEST);
	localparam logic signed [AIN_W-1:0] ANG_HI_IN = AIN_W'(ANGLE_HIGHEST);

	localparam int HOME_INIT_LEN = 24;
	localparam int HOME_INIT [HOME_INIT_LEN] = '{
		-40, 245, 470, -100, -205, 50, 445, 245, -75, 0, 0, 0,
		15, -70, -390, 250, 195, -105, -510, -305, 60, 0, 0, 0
	};

	typedef enum logic [OP_W-1:0] {
		OP_SET_ANGLE  = 3'd0,
		OP_SET_OFFSET = 3'd1,
		OP_SET_MIN    = 3'd2,
		OP_SET_MAX    = 3'd3,
		OP_SET_HOME   = 3'd4,
		OP_READ       = 3'd5
	} op_t;

	typedef struct packed {
		logic load_in;
		logic rd;
		logic clamp;
		logic mul;
		logic rcp;
		logic cor;
		logic wb;
	} ctl_cmd_t;

	typedef struct packed {
		logic drive;
	} dp_stat_t;

	function automatic int home_reset_int(int j);
		int v;
		v = 0;
		if (j < HOME_INIT_LEN) begin
			v = HOME_INIT[j];
		end
		return v;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] home_reset(int j);
		return ANGLE_W'(home_reset_int(j));
	endfunction

	// Pulse of the home angle with the direction bit at its reset value.
	function automatic logic [PULSE_W-1:0] pulse_reset(int j);
		int a;
		int v;
		a = home_reset_int(j);
		if (a < ANGLE_LOWEST) a = ANGLE_LOWEST;
		if (a > ANGLE_HIGHEST) a = ANGLE_HIGHEST;
		if (j == SPECIAL_JOINT_A || j == SPECIAL_JOINT_B) begin
			v = CENTER_PULSE - a / ANGLE_SCALE;
		end else begin
			v = ((a - ANGLE_LOWEST) * (PULSE_LOW - PULSE_HIGH)) / ANGLE_SPAN + PULSE_HIGH;
		end
		if (v < 0) v = 0;
		if (v > PULSE_MAX) v = PULSE_MAX;
		return PULSE_W'(v);
	endfunction

endpackage

// ----- src/sjl_ctrl.sv -----
module sjl_ctrl import sjl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CLAMP,
		ST_MUL,
		ST_RCP,
		ST_COR,
		ST_WB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.load_in = (state_q == ST_IDLE) && s_tvalid;
		cmd.rd      = (state_q == ST_READ);
		cmd.clamp   = (state_q == ST_CLAMP);
		cmd.mul     = (state_q == ST_MUL);
		cmd.rcp     = (state_q == ST_RCP);
		cmd.cor     = (state_q == ST_COR);
		cmd.wb      = (state_q == ST_WB) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_WB && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_READ;
				end
				ST_READ: begin
					// Only drive commands need the pulse arithmetic.
					state_q <= stat.drive ? ST_CLAMP : ST_WB;
				end
				ST_CLAMP: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_RCP;
				ST_RCP:   state_q <= ST_COR;
				ST_COR:   state_q <= ST_WB;
				ST_WB: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/sjl_datapath.sv -----
module sjl_datapath import sjl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [OP_W-1:0]       in_op,
	input  logic                  cfg_wen,
	input  logic                  cfg_wdata,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_accepted
);

	logic [OP_W-1:0]           op_q;
	logic [JOINT_W-1:0]        joint_q;
	logic signed [AIN_W-1:0]   ain_q;
	logic                      cw_q;

	logic signed [ANGLE_W-1:0] min_q   [JOINT_COUNT];
	logic signed [ANGLE_W-1:0] max_q   [JOINT_COUNT];
	logic signed [ANGLE_W-1:0] home_q  [JOINT_COUNT];
	logic [PULSE_W-1:0]        pulse_q [JOINT_COUNT];

	logic                      jvalid;
	logic [JIDX_W-1:0]         idx;
	logic                      special;

	logic signed [ANGLE_W-1:0] mn_s1, mx_s1, hm_s1;
	logic [PULSE_W-1:0]        pl_s1;
	logic signed [ANGLE_W-1:0] ang_s2;
	logic [P_W-1:0]            p_s3, p_s4;
	logic                      spec_s3, spec_s4;
	logic                      sub_s3, sub_s4, sub_s5;
	logic [PULSE_W-1:0]        base_s3, base_s4, base_s5;
	logic [P_W-1:0]            qe_s4, q_s5;

	logic signed [AIN_W:0]     tgt;
	logic signed [ANGLE_W-1:0] ang_c;
	logic signed [AIN_W-1:0]   ang_x;
	logic [AIN_W-1:0]          mag;
	logic [AIN_W-1:0]          ang_ofs;
	logic [P_W+RCP_W-1:0]      rcp_prod;
	logic [RCP_W-1:0]          rcp;
	logic [DIV_W-1:0]          divv;
	logic [P_W-1:0]            qd;
	logic [P_W-1:0]            rem;
	logic signed [P_W+1:0]     sum;
	logic [PULSE_W-1:0]        pulse_new;

	logic signed [ANGLE_W-1:0] nmn, nmx, nhm;
	logic [PULSE_W-1:0]        npl;
	logic                      ok;

	assign jvalid  = ({1'b0, joint_q} < (JOINT_W + 1)'(JOINT_COUNT));
	assign idx     = joint_q[JIDX_W-1:0];
	assign special = (joint_q == JOINT_W'(SPECIAL_JOINT_A)) ||
	                 (joint_q == JOINT_W'(SPECIAL_JOINT_B));
	assign stat.drive = jvalid &&
	                    (op_t'(op_q) == OP_SET_ANGLE || op_t'(op_q) == OP_SET_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= 1'b0;
		end else if (cfg_wen) begin
			cw_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= in_op;
			joint_q <= in_data[JOINT_W-1:0];
			ain_q   <= $signed(in_data[JOINT_W +: AIN_W]);
		end
		if (cmd.rd) begin
			mn_s1 <= min_q[idx];
			mx_s1 <= max_q[idx];
			hm_s1 <= home_q[idx];
			pl_s1 <= pulse_q[idx];
		end
		if (cmd.clamp) begin
			ang_s2 <= ang_c;
		end
		if (cmd.mul) begin
			spec_s3 <= special;
			if (special) begin
				p_s3    <= P_W'(mag);
				sub_s3  <= (cw_q == ang_x[AIN_W-1]);
				base_s3 <= PULSE_W'(CENTER_PULSE);
			end else begin
				p_s3    <= P_W'(ang_ofs) * P_W'(PULSE_SPAN_ABS);
				sub_s3  <= (cw_q == PULSE_SPAN_NEG);
				base_s3 <= cw_q ? PULSE_W'(PULSE_LOW) : PULSE_W'(PULSE_HIGH);
			end
		end
		if (cmd.rcp) begin
			qe_s4   <= P_W'(rcp_prod >> RCP_SH);
			p_s4    <= p_s3;
			spec_s4 <= spec_s3;
			sub_s4  <= sub_s3;
			base_s4 <= base_s3;
		end
		if (cmd.cor) begin
			q_s5    <= qe_s4 + P_W'(rem >= P_W'(divv));
			sub_s5  <= sub_s4;
			base_s5 <= base_s4;
		end
	end

	// Target angle and clamp to the joint's limits.
	always_comb begin
		if (op_t'(op_q) == OP_SET_OFFSET) begin
			tgt = (AIN_W + 1)'(ain_q) + (AIN_W + 1)'(hm_s1);
		end else begin
			tgt = (AIN_W + 1)'(ain_q);
		end
		if (tgt < (AIN_W + 1)'(mn_s1)) begin
			ang_c = mn_s1;
		end else if (tgt > (AIN_W + 1)'(mx_s1)) begin
			ang_c = mx_s1;
		end else begin
			ang_c = ANGLE_W'(tgt);
		end
	end

	assign ang_x   = AIN_W'(ang_s2);
	assign mag     = ang_x[AIN_W-1] ? unsigned'(-ang_x) : unsigned'(ang_x);
	assign ang_ofs = unsigned'(AIN_W'(ang_x - ANG_LO_IN));

	// The reciprocal estimate is never above the true quotient and at most one below.
	assign rcp      = spec_s3 ? RCP_W'(RCP_SCALE) : RCP_W'(RCP_SPAN);
	assign rcp_prod = (P_W + RCP_W)'(p_s3) * (P_W + RCP_W)'(rcp);
	assign divv     = spec_s4 ? DIV_W'(ANGLE_SCALE) : DIV_W'(ANGLE_SPAN);
	assign qd       = P_W'(qe_s4 * P_W'(divv));
	assign rem      = p_s4 - qd;

	always_comb begin
		if (sub_s5) begin
			sum = (P_W + 2)'(signed'({1'b0, base_s5})) - (P_W + 2)'(signed'({1'b0, q_s5}));
		end else begin
			sum = (P_W + 2)'(signed'({1'b0, base_s5})) + (P_W + 2)'(signed'({1'b0, q_s5}));
		end
		if (sum < 0) begin
			pulse_new = '0;
		end else if (sum > (P_W + 2)'(PULSE_MAX)) begin
			pulse_new = PULSE_W'(PULSE_MAX);
		end else begin
			pulse_new = PULSE_W'(sum);
		end
	end

	always_comb begin
		nmn = mn_s1;
		nmx = mx_s1;
		nhm = hm_s1;
		npl = pl_s1;
		ok  = 1'b0;
		case (op_t'(op_q))
			OP_SET_ANGLE, OP_SET_OFFSET: begin
				npl = pulse_new;
				ok  = 1'b1;
			end
			OP_SET_MIN: begin
				if (ain_q < AIN_W'(mx_s1) && ain_q >= ANG_LO_IN) begin
					nmn = ANGLE_W'(ain_q);
					ok  = 1'b1;
				end
			end
			OP_SET_MAX: begin
				if (ain_q > AIN_W'(mn_s1) && ain_q <= ANG_HI_IN) begin
					nmx = ANGLE_W'(ain_q);
					ok  = 1'b1;
				end
			end
			OP_SET_HOME: begin
				if (ain_q >= AIN_W'(mn_s1) && ain_q <= AIN_W'(mx_s1)) begin
					nhm = ANGLE_W'(ain_q);
					ok  = 1'b1;
				end
			end
			OP_READ: ok = 1'b1;
			default: ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < JOINT_COUNT; j++) begin
				min_q[j]   <= ANG_LO;
				max_q[j]   <= ANG_HI;
				home_q[j]  <= home_reset(j);
				pulse_q[j] <= pulse_reset(j);
			end
		end else if (cmd.wb && jvalid) begin
			min_q[idx]   <= nmn;
			max_q[idx]   <= nmx;
			home_q[idx]  <= nhm;
			pulse_q[idx] <= npl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			if (jvalid) begin
				out_accepted <= ok;
				out_data     <= {npl, AIN_W'(nhm), AIN_W'(nmx), AIN_W'(nmn)};
			end else begin
				out_accepted <= 1'b0;
				out_data     <= '0;
			end
		end
	end

endmodule

// ----- src/servo_joint_limit_table.sv -----
// Servo joint limit table: a command beat on the slave side names a joint and an angle and
// sets the angle, sets an offset from home, edits the minimum, maximum or home angle, or
// reads the entry; one result beat per command reports whether it was taken and the joint's
// entries afterwards. Commands are handled one at a time. A drive command (set angle or
// offset) on a valid joint passes through table read, clamp, scaling multiply, reciprocal
// multiply and correction of the constant divider, then write-back; every other command,
// and a drive on an invalid joint, goes from table read straight to write-back.
// The result register lets the next command be taken while a result still waits; a command
// reaching write-back while the previous result is still held waits until it is taken. The
// clockwise_mode bit must be written through cfg_wen and cfg_wdata only while no command is
// in flight, which the block does not enforce itself, and affects only later drive commands.
module servo_joint_limit_table import sjl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// joint[4:0], angle_value[16:5], zero fill [23:17]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[2:0]
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// min_angle[11:0], max_angle[23:12], home_angle[35:24], pulse_value[47:36]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// accepted[0]
	output logic [0:0]            m_tuser,
	input  logic                  cfg_wen,
	input  logic                  cfg_wdata
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	sjl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sjl_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_data      (s_tdata),
		.in_op        (s_tuser),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.out_data     (m_tdata),
		.out_accepted (m_tuser[0])
	);

endmodule

// ----- src/sjl_checker.sv -----
module sjl_checker import sjl_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]            m_tuser
);

	// A command is worked on alone, so the slave side closes right after a beat.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("slave side ready again right after a command beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result beat changed or dropped");

	// Limits of a valid joint always keep the minimum below the maximum.
	a_limits_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[11:0] != '0 || m_tdata[23:12] != '0)) |->
		($signed(m_tdata[11:0]) < $signed(m_tdata[23:12])))
		else $error("result shows minimum not below maximum");

	// An accepted command names a valid joint, whose limits are never both zero.
	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[11:0] != '0 || m_tdata[23:12] != '0))
		else $error("accepted result with all-zero limits");

endmodule

bind servo_joint_limit_table sjl_checker u_sjl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
